FILE: rtl/core/bld_pkg.sv
// ----------------------------------------------------------------------------
// bld_pkg: shared types, constants and keyword ROM
// Definitions used by the tokenized BASIC listing detokenizer.
// ----------------------------------------------------------------------------
package bld_pkg;

  localparam logic [7:0] KwFirst = 8'h80;
  localparam logic [7:0] KwLast  = 8'hf2;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChOpen  = 8'h5b;
  localparam logic [7:0] ChClose = 8'h5d;
  localparam logic [15:0] LineOverhead = 16'd5;
  localparam int unsigned OutDataW = 80;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_LINE = 2'd1,
    KIND_EOF  = 2'd2
  } kind_e;

  typedef enum logic [8:0] {
    PH_SIZE_LO = 9'b0_0000_0001,
    PH_SIZE_HI = 9'b0_0000_0010,
    PH_LINK_LO = 9'b0_0000_0100,
    PH_LINK_HI = 9'b0_0000_1000,
    PH_NUM_LO  = 9'b0_0001_0000,
    PH_NUM_HI  = 9'b0_0010_0000,
    PH_BODY    = 9'b0_0100_0000,
    PH_QUOTE   = 9'b0_1000_0000,
    PH_AFTER   = 9'b1_0000_0000
  } phase_e;

  // One decoded beat: string of up to seven chars, or a report.
  typedef struct packed {
    logic        is_text;
    logic [2:0]  len;          // chars in str, 1..7
    logic [55:0] str;          // char i at [8*i +: 8]
    kind_e       kind;         // report kind when not is_text
    logic [15:0] line_number;
    logic [15:0] line_start;
    logic [15:0] line_end;
    logic        link_mismatch;
    logic [15:0] trailing_count;
    logic        eof_error;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    begin
      c = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
      return c;
    end
  endfunction

  // Pack a keyword string: char 0 in lowest bits.
  function automatic logic [58:0] kw(input string s);
    logic [58:0] r;
    begin
      r = '0;
      for (int i = 0; i < s.len(); i++) begin
        r[8*i +: 8] = 8'(s[i]);
      end
      r[58:56] = 3'(s.len());
      return r;
    end
  endfunction

  // Returns {len, string}.
  function automatic logic [58:0] keyword_rom(input logic [6:0] idx);
    logic [58:0] r;
    begin
      unique case (idx)
        7'd0: r = kw("END");     7'd1: r = kw("FOR");    7'd2: r = kw("NEXT");
        7'd3: r = kw("DATA");    7'd4: r = kw("INPUT");  7'd5: r = kw("DIM");
        7'd6: r = kw("READ");    7'd7: r = kw("LET");    7'd8: r = kw("GOTO");
        7'd9: r = kw("RUN");     7'd10: r = kw("IF");    7'd11: r = kw("RESTORE");
        7'd12: r = kw("GOSUB");  7'd13: r = kw("RETURN"); 7'd14: r = kw("REM");
        7'd15: r = kw("STOP");   7'd16: r = kw("OUT");   7'd17: r = kw("ON");
        7'd18: r = kw("NULL");   7'd19: r = kw("WAIT");  7'd20: r = kw("DEF");
        7'd21: r = kw("POKE");   7'd22: r = kw("DOKE");  7'd23: r = kw("AUTO");
        7'd24: r = kw("LINES");  7'd25: r = kw("CLS");   7'd26: r = kw("WIDTH");
        7'd27: r = kw("BYE");    7'd28: r = kw("!");     7'd29: r = kw("CALL");
        7'd30: r = kw("PRINT");  7'd31: r = kw("CONT");  7'd32: r = kw("LIST");
        7'd33: r = kw("CLEAR");  7'd34: r = kw("CLOAD"); 7'd35: r = kw("CSAVE");
        7'd36: r = kw("NEW");    7'd37: r = kw("TAB(");  7'd38: r = kw("TO");
        7'd39: r = kw("FN");     7'd40: r = kw("SPC(");  7'd41: r = kw("THEN");
        7'd42: r = kw("NOT");    7'd43: r = kw("STEP");  7'd44: r = kw("+");
        7'd45: r = kw("-");      7'd46: r = kw("*");     7'd47: r = kw("/");
        7'd48: r = kw("^");      7'd49: r = kw("AND");   7'd50: r = kw("OR");
        7'd51: r = kw(">");      7'd52: r = kw("=");     7'd53: r = kw("<");
        7'd54: r = kw("SGN");    7'd55: r = kw("INT");   7'd56: r = kw("ABS");
        7'd57: r = kw("USR");    7'd58: r = kw("FRE");   7'd59: r = kw("INP");
        7'd60: r = kw("POS");    7'd61: r = kw("SQR");   7'd62: r = kw("RND");
        7'd63: r = kw("LN");     7'd64: r = kw("EXP");   7'd65: r = kw("COS");
        7'd66: r = kw("SIN");    7'd67: r = kw("TAN");   7'd68: r = kw("ATN");
        7'd69: r = kw("PEEK");   7'd70: r = kw("DEEK");  7'd71: r = kw("PI");
        7'd72: r = kw("LEN");    7'd73: r = kw("STR$");  7'd74: r = kw("VAL");
        7'd75: r = kw("ASC");    7'd76: r = kw("CHR$");  7'd77: r = kw("LEFT$");
        7'd78: r = kw("RIGHT$"); 7'd79: r = kw("MID$");  7'd80: r = kw("LOAD");
        7'd81: r = kw("TRON");   7'd82: r = kw("TROFF"); 7'd83: r = kw("EDIT");
        7'd84: r = kw("ELSE");   7'd85: r = kw("INKEY$"); 7'd86: r = kw("JOYST");
        7'd87: r = kw("STRING$"); 7'd88: r = kw("INSTR"); 7'd89: r = kw("RENUM");
        7'd90: r = kw("DELETE"); 7'd91: r = kw("PAUSE"); 7'd92: r = kw("BEEP");
        7'd93: r = kw("WINDOW"); 7'd94: r = kw("BORDER"); 7'd95: r = kw("INK");
        7'd96: r = kw("PAPER");  7'd97: r = kw("AT");    7'd98: r = kw("PSET");
        7'd99: r = kw("LINE");   7'd100: r = kw("CIRCLE"); 7'd101: r = kw("!");
        7'd102: r = kw("PAINT"); 7'd103: r = kw("LABEL"); 7'd104: r = kw("SIZE");
        7'd105: r = kw("ZERO");  7'd106: r = kw("HOME"); 7'd107: r = kw("!");
        7'd108: r = kw("GCLS");  7'd109: r = kw("SCALE"); 7'd110: r = kw("SCREEN");
        7'd111: r = kw("POINT"); 7'd112: r = kw("XPOS"); 7'd113: r = kw("!");
        7'd114: r = kw("YPOS");
        default: r = kw("!");
      endcase
      return r;
    end
  endfunction

endpackage

FILE: rtl/core/bld_parse.sv
// ----------------------------------------------------------------------------
// bld_parse: stream parser
// Tracks the phase; each body, line-end or EOF beat makes one job.
// ----------------------------------------------------------------------------
module bld_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           binary_mode_i,
  input  logic           in_valid_i,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_file_i,
  output logic           job_valid_o,
  output bld_pkg::job_t  job_o
);

  bld_pkg::phase_e phase_q, phase_d;
  logic [15:0] link_q, link_d;
  logic [15:0] prev_q, prev_d;
  logic [15:0] blen_q, blen_d;
  logic [15:0] num_q, num_d;
  logic [15:0] after_q, after_d;
  logic [15:0] start;
  logic [58:0] kwv;
  logic        printable;
  logic [7:0]  filt;

  assign start     = link_q - blen_q - bld_pkg::LineOverhead;
  assign kwv       = bld_pkg::keyword_rom(7'(data_byte_i - bld_pkg::KwFirst));
  assign printable = (data_byte_i >= 8'h20) && (data_byte_i <= 8'h7e);
  assign filt      = (printable || binary_mode_i) ? data_byte_i : bld_pkg::ChDot;

  always_comb begin
    phase_d = phase_q;
    link_d  = link_q;
    prev_d  = prev_q;
    blen_d  = blen_q;
    num_d   = num_q;
    after_d = after_q;
    job_valid_o = 1'b0;
    job_o = '0;
    job_o.kind = bld_pkg::KIND_CHAR;
    if (in_valid_i) begin
      if (end_of_file_i) begin
        job_valid_o = 1'b1;
        job_o.kind  = bld_pkg::KIND_EOF;
        if (phase_q == bld_pkg::PH_AFTER) begin
          job_o.trailing_count = after_q;
        end else begin
          job_o.eof_error = 1'b1;
        end
        phase_d = bld_pkg::PH_SIZE_LO;
      end else begin
        unique case (phase_q)
          bld_pkg::PH_SIZE_LO: begin
            after_d = '0;
            prev_d  = '0;
            phase_d = bld_pkg::PH_SIZE_HI;
          end
          bld_pkg::PH_SIZE_HI: phase_d = bld_pkg::PH_LINK_LO;
          bld_pkg::PH_LINK_LO: begin
            link_d  = {8'd0, data_byte_i};
            phase_d = bld_pkg::PH_LINK_HI;
          end
          bld_pkg::PH_LINK_HI: begin
            link_d  = {data_byte_i, link_q[7:0]};
            phase_d = (link_d == 16'd0) ? bld_pkg::PH_AFTER : bld_pkg::PH_NUM_LO;
          end
          bld_pkg::PH_NUM_LO: begin
            num_d   = {8'd0, data_byte_i};
            phase_d = bld_pkg::PH_NUM_HI;
          end
          bld_pkg::PH_NUM_HI: begin
            num_d   = {data_byte_i, num_q[7:0]};
            blen_d  = '0;
            phase_d = bld_pkg::PH_BODY;
          end
          bld_pkg::PH_BODY, bld_pkg::PH_QUOTE: begin
            job_valid_o = 1'b1;
            if (data_byte_i == 8'd0) begin
              job_o.kind          = bld_pkg::KIND_LINE;
              job_o.line_number   = num_q;
              job_o.line_start    = start;
              job_o.line_end      = link_q - 16'd1;
              job_o.link_mismatch = (prev_q != 16'd0) && (prev_q != start);
              prev_d  = link_q;
              phase_d = bld_pkg::PH_LINK_LO;
            end else begin
              blen_d = blen_q + 16'd1;
              job_o.is_text = 1'b1;
              if (phase_q == bld_pkg::PH_BODY && data_byte_i[7]) begin
                if (data_byte_i <= bld_pkg::KwLast) begin
                  job_o.len = kwv[58:56];
                  job_o.str = kwv[55:0];
                end else begin
                  job_o.len = 3'd4;
                  job_o.str[7:0]   = bld_pkg::ChOpen;
                  job_o.str[15:8]  = bld_pkg::hex_char(data_byte_i[7:4]);
                  job_o.str[23:16] = bld_pkg::hex_char(data_byte_i[3:0]);
                  job_o.str[31:24] = bld_pkg::ChClose;
                end
              end else begin
                job_o.len = 3'd1;
                job_o.str[7:0] = filt;
              end
              if (data_byte_i == bld_pkg::ChQuote) begin
                phase_d = (phase_q == bld_pkg::PH_BODY) ? bld_pkg::PH_QUOTE
                                                        : bld_pkg::PH_BODY;
              end
            end
          end
          bld_pkg::PH_AFTER: begin
            if (after_q != 16'hffff) after_d = after_q + 16'd1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bld_pkg::PH_SIZE_LO;
      link_q  <= '0;
      prev_q  <= '0;
      blen_q  <= '0;
      num_q   <= '0;
      after_q <= '0;
    end else begin
      phase_q <= phase_d;
      link_q  <= link_d;
      prev_q  <= prev_d;
      blen_q  <= blen_d;
      num_q   <= num_d;
      after_q <= after_d;
    end
  end

endmodule

FILE: rtl/core/bld_emit.sv
// ----------------------------------------------------------------------------
// bld_emit: job register and output serializer
// Holds one job and sends its characters or report beat by beat.
// ----------------------------------------------------------------------------
module bld_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  bld_pkg::job_t  job_i,
  output logic           job_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [bld_pkg::OutDataW-1:0] out_data_o,
  output logic           out_last_o
);

  logic          full_q;
  bld_pkg::job_t job_q;
  logic [2:0]    idx_q;
  logic          last_beat;
  logic [7:0]    ch;

  assign ch        = job_q.str[{idx_q, 3'b000} +: 8];
  assign last_beat = !job_q.is_text || (idx_q == job_q.len - 3'd1);
  assign out_valid_o = full_q;
  assign out_last_o  = last_beat;
  assign job_ready_o = !full_q || (out_ready_i && last_beat);

  always_comb begin
    out_data_o = '0;
    out_data_o[1:0] = job_q.is_text ? bld_pkg::KIND_CHAR : job_q.kind;
    if (job_q.is_text) begin
      out_data_o[9:2] = ch;
    end else begin
      out_data_o[25:10] = job_q.line_number;
      out_data_o[41:26] = job_q.line_start;
      out_data_o[57:42] = job_q.line_end;
      out_data_o[58]    = job_q.link_mismatch;
      out_data_o[74:59] = job_q.trailing_count;
      out_data_o[75]    = job_q.eof_error;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      idx_q  <= '0;
    end else if (job_ready_o) begin
      full_q <= job_valid_i;
      idx_q  <= '0;
    end else if (out_ready_i) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_ready_o && job_valid_i) job_q <= job_i;
  end

endmodule

FILE: rtl/core/basic_listing_detokenizer.sv
// ----------------------------------------------------------------------------
// basic_listing_detokenizer: tokenized BASIC listing detokenizer
// Expands a tokenized program byte stream into listing text and reports.
// ----------------------------------------------------------------------------
// Output: the first output beat for an input beat appears in the cycle after that input beat is accepted.
// Throughput: one input beat per cycle for header, plain and line-end bytes while
// the output is not stalled; a keyword or hex escape holds the input until the
// one-character-per-beat output serializer has sent all its characters (up to 7).
// Reset: async active low; phase and line state clear, binary_mode off.
module basic_listing_detokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [bld_pkg::OutDataW-1:0] m_axis_tdata,
  // kind[1:0] char_code[9:2] line_number[25:10] line_start[41:26]
  // line_end[57:42] link_mismatch[58] trailing_count[74:59] eof_error[75]
  output logic        m_axis_tlast    // last_of_run
);

  logic          bin_q;
  logic          job_valid;
  bld_pkg::job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bin_q <= 1'b0;
    else if (cfg_we_i) bin_q <= cfg_wdata_i;
  end

  bld_parse u_parse (
    .clk_i, .rst_ni,
    .binary_mode_i (bin_q),
    .in_valid_i    (s_axis_tvalid && s_axis_tready),
    .data_byte_i   (s_axis_tdata),
    .end_of_file_i (s_axis_tuser),
    .job_valid_o   (job_valid),
    .job_o         (job)
  );

  bld_emit u_emit (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: dv/tb_basic_listing_detokenizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_basic_listing_detokenizer: self-checking bench for the detokenizer
// Sends tokenized programs (well-formed, broken and noisy) with random gaps
// and output stalls, predicts every listing character and report, and
// compares each output beat against the oldest expected beat.
// ----------------------------------------------------------------------------
module tb_basic_listing_detokenizer;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned OutW = bld_pkg::OutDataW;

  typedef struct packed {
    logic       eof;
    logic [7:0] data;
  } in_beat_t;

  typedef struct packed {
    logic            last;
    logic [OutW-1:0] data;
  } out_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic m_axis_tlast;

  in_beat_t  pending_q[$];
  out_beat_t listing_q[$];

  // predictor state
  logic            bin_mode = 1'b0;
  bld_pkg::phase_e ph = bld_pkg::PH_SIZE_LO;
  logic [15:0]     link_addr = '0;
  logic [15:0]     prev_link = '0;
  logic [15:0]     body_len = '0;
  logic [15:0]     line_num = '0;
  logic [15:0]     trail_cnt = '0;

  int errors = 0;
  int idle_cycles = 0;
  int acc_cnt = 0;
  int seen_cnt = 0;
  int send_gap = 0;
  int recv_gap = 0;

  always #1 clk_i = ~clk_i;

  basic_listing_detokenizer dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic string keyword_text(input logic [7:0] b);
    string names[115] = '{
      "END", "FOR", "NEXT", "DATA", "INPUT", "DIM", "READ", "LET",
      "GOTO", "RUN", "IF", "RESTORE", "GOSUB", "RETURN", "REM", "STOP",
      "OUT", "ON", "NULL", "WAIT", "DEF", "POKE", "DOKE", "AUTO",
      "LINES", "CLS", "WIDTH", "BYE", "!", "CALL", "PRINT", "CONT",
      "LIST", "CLEAR", "CLOAD", "CSAVE", "NEW", "TAB(", "TO", "FN",
      "SPC(", "THEN", "NOT", "STEP", "+", "-", "*", "/",
      "^", "AND", "OR", ">", "=", "<", "SGN", "INT",
      "ABS", "USR", "FRE", "INP", "POS", "SQR", "RND", "LN",
      "EXP", "COS", "SIN", "TAN", "ATN", "PEEK", "DEEK", "PI",
      "LEN", "STR$", "VAL", "ASC", "CHR$", "LEFT$", "RIGHT$", "MID$",
      "LOAD", "TRON", "TROFF", "EDIT", "ELSE", "INKEY$", "JOYST", "STRING$",
      "INSTR", "RENUM", "DELETE", "PAUSE", "BEEP", "WINDOW", "BORDER", "INK",
      "PAPER", "AT", "PSET", "LINE", "CIRCLE", "!", "PAINT", "LABEL",
      "SIZE", "ZERO", "HOME", "!", "GCLS", "SCALE", "SCREEN", "POINT",
      "XPOS", "!", "YPOS"};
    return names[b - bld_pkg::KwFirst];
  endfunction

  function automatic logic [7:0] to_hex(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h61 + 8'(v) - 8'd10;
  endfunction

  function automatic logic [OutW-1:0] char_beat(input logic [7:0] c);
    logic [OutW-1:0] d;
    d = '0;
    d[1:0] = bld_pkg::KIND_CHAR;
    d[9:2] = c;
    return d;
  endfunction

  // Compute the listing beats for one accepted input beat.
  task automatic detokenize(input in_beat_t ib);
    logic [OutW-1:0] res[$];
    logic [OutW-1:0] d;
    logic [15:0] start;
    string s;
    logic [7:0] b;
    b = ib.data;
    if (ib.eof) begin
      d = '0;
      d[1:0] = bld_pkg::KIND_EOF;
      if (ph == bld_pkg::PH_AFTER) d[74:59] = trail_cnt;
      else d[75] = 1'b1;
      res.push_back(d);
      ph = bld_pkg::PH_SIZE_LO;
    end else begin
      case (ph)
        bld_pkg::PH_SIZE_LO: begin
          trail_cnt = '0;
          prev_link = '0;
          ph = bld_pkg::PH_SIZE_HI;
        end
        bld_pkg::PH_SIZE_HI: ph = bld_pkg::PH_LINK_LO;
        bld_pkg::PH_LINK_LO: begin
          link_addr = {8'd0, b};
          ph = bld_pkg::PH_LINK_HI;
        end
        bld_pkg::PH_LINK_HI: begin
          link_addr[15:8] = b;
          ph = (link_addr == 16'd0) ? bld_pkg::PH_AFTER : bld_pkg::PH_NUM_LO;
        end
        bld_pkg::PH_NUM_LO: begin
          line_num = {8'd0, b};
          ph = bld_pkg::PH_NUM_HI;
        end
        bld_pkg::PH_NUM_HI: begin
          line_num[15:8] = b;
          body_len = '0;
          ph = bld_pkg::PH_BODY;
        end
        bld_pkg::PH_BODY, bld_pkg::PH_QUOTE: begin
          if (b == 8'd0) begin
            start = link_addr - body_len - bld_pkg::LineOverhead;
            d = '0;
            d[1:0] = bld_pkg::KIND_LINE;
            d[25:10] = line_num;
            d[41:26] = start;
            d[57:42] = link_addr - 16'd1;
            d[58] = (prev_link != 0) && (prev_link != start);
            res.push_back(d);
            prev_link = link_addr;
            ph = bld_pkg::PH_LINK_LO;
          end else begin
            body_len++;
            if (ph == bld_pkg::PH_BODY && b[7]) begin
              if (b <= bld_pkg::KwLast) begin
                s = keyword_text(b);
                for (int i = 0; i < s.len(); i++) res.push_back(char_beat(8'(s[i])));
              end else begin
                res.push_back(char_beat(bld_pkg::ChOpen));
                res.push_back(char_beat(to_hex(b[7:4])));
                res.push_back(char_beat(to_hex(b[3:0])));
                res.push_back(char_beat(bld_pkg::ChClose));
              end
            end else if ((b >= 8'h20 && b <= 8'h7e) || bin_mode) begin
              res.push_back(char_beat(b));
            end else begin
              res.push_back(char_beat(bld_pkg::ChDot));
            end
            if (b == bld_pkg::ChQuote) begin
              ph = (ph == bld_pkg::PH_BODY) ? bld_pkg::PH_QUOTE : bld_pkg::PH_BODY;
            end
          end
        end
        bld_pkg::PH_AFTER: if (trail_cnt != 16'hffff) trail_cnt++;
        default: ;
      endcase
    end
    foreach (res[i]) listing_q.push_back('{last: (i == res.size() - 1), data: res[i]});
  endtask

  task automatic put(input logic [7:0] b);
    pending_q.push_back('{eof: 1'b0, data: b});
  endtask

  task automatic put_eof();
    pending_q.push_back('{eof: 1'b1, data: 8'($urandom_range(0, 255))});
  endtask

  task automatic put_word(input logic [15:0] w);
    put(w[7:0]);
    put(w[15:8]);
  endtask

  // Random program; if broken, can end at EOF mid-line; links usually chain.
  task automatic put_program(input int n_lines, input bit broken);
    logic [15:0] addr, nxt;
    int len, r;
    logic [7:0] body[$];
    addr = 16'($urandom_range(0, 65535));
    put_word(16'($urandom_range(0, 65535)));
    for (int l = 0; l < n_lines; l++) begin
      len = $urandom_range(0, 6);
      body.delete();
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 9);
        if (r < 3) body.push_back(8'($urandom_range(8'h80, 8'hff)));
        else if (r < 4) body.push_back(bld_pkg::ChQuote);
        else body.push_back(8'($urandom_range(1, 255)));
      end
      nxt = addr + 16'(len) + 16'd5;
      if ($urandom_range(0, 7) == 0) nxt = 16'($urandom_range(1, 65535));
      if (nxt == 0) nxt = 16'd1;
      put_word(nxt);
      put_word(16'($urandom_range(0, 65535)));
      foreach (body[k]) put(body[k]);
      if (broken && l == n_lines - 1 && $urandom_range(0, 1)) begin
        put_eof();
        return;
      end
      put(8'd0);
      addr = nxt;
    end
    put_word(16'd0);
    r = $urandom_range(0, 4);
    for (int k = 0; k < r; k++) put(8'($urandom_range(0, 255)));
    put_eof();
  endtask

  // Wait until the block has drained and is idle.
  task automatic drain();
    while (pending_q.size() != 0 || listing_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    bin_mode = v;
  endtask

  // driver
  always @(negedge clk_i) begin
    logic vld;
    vld = s_axis_tvalid;
    if (rst_ni) begin
      if (acc_cnt != seen_cnt) begin
        seen_cnt = acc_cnt;
        vld = 1'b0;
        if ($urandom_range(0, 2) == 0) send_gap = rand_gap();
      end
      if (!vld) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
        end else if (pending_q.size() != 0) begin
          vld = 1'b1;
          s_axis_tdata <= pending_q[0].data;
          s_axis_tuser <= pending_q[0].eof;
        end
      end
      s_axis_tvalid <= vld;
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap <= rand_gap();
      end
    end
  end

  // input acceptance and prediction
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      detokenize(pending_q.pop_front());
      acc_cnt <= acc_cnt + 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_beat_t e;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (rst_ni)
      idle_cycles <= idle_cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      if (listing_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat data=%h last=%b", m_axis_tdata, m_axis_tlast);
      end else begin
        e = listing_q.pop_front();
        if (e.data !== m_axis_tdata || e.last !== m_axis_tlast) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp data=%h last=%b got data=%h last=%b",
                     e.data, e.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
    if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: keyword extremes, hex escapes, quotes, filter, eof error
    put_word(16'h0000);
    put_word(16'h1008);
    put_word(16'hffff);
    put(8'h80); put(8'hf2); put(8'hf3); put(8'hff);
    put(bld_pkg::ChQuote); put(8'h81); put(8'h01); put(bld_pkg::ChQuote); put(8'h7f);
    put(8'd0);
    put_word(16'h0000);
    put(8'h55); put(8'haa);
    put_eof();
    put_word(16'h1234); put_word(16'h0001); put(8'h41);
    put_eof();
    put_eof();
    drain();

    write_mode(1'b1);
    put_word(16'h0); put_word(16'h0105); put_word(16'h0000);
    put(8'h01); put(8'hfe); put(bld_pkg::ChQuote); put(8'h90); put(8'd0);
    put_word(16'h0); put_eof();
    drain();

    for (int p = 0; p < 3; p++) begin
      write_mode(p[0]);
      for (int k = 0; k < 3; k++) put_program($urandom_range(1, 3), k == 2);
      r = $urandom_range(0, 6);
      for (int k = 0; k < r; k++) put(8'($urandom_range(0, 255)));
      put_eof();
      drain();
    end

    // trailing bytes after the end marker
    write_mode(1'b0);
    put_word(16'h0); put_word(16'h0);
    for (int k = 0; k < 20; k++) put(8'($urandom_range(0, 255)));
    put_eof();
    drain();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bld_pkg.sv
rtl/core/bld_parse.sv
rtl/core/bld_emit.sv
rtl/core/basic_listing_detokenizer.sv
dv/tb_basic_listing_detokenizer.sv
